// ===== src/complex_arithmetic_unit_assert.svh =====
// Assertion helpers for the RTL file that checks itself.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk and off during reset.
`define CAU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("complex_arithmetic_unit assertion failed");

// Next-cycle implication, clocked on clk and off during reset.
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("complex_arithmetic_unit assertion failed");

`endif

// ===== src/cau_pkg.sv =====
`default_nettype none

package cau_pkg;

    localparam int QW = 17;

    localparam logic [2:0] KIND_ADD  = 3'd0;
    localparam logic [2:0] KIND_SUB  = 3'd1;
    localparam logic [2:0] KIND_MUL  = 3'd2;
    localparam logic [2:0] KIND_DIV  = 3'd3;
    localparam logic [2:0] KIND_CONJ = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic        valid;
        logic        is_div;
        logic        div0;
        logic        neg_re;
        logic        neg_im;
        logic        ovf_re;
        logic        ovf_im;
        logic [15:0] res_re;
        logic [15:0] res_im;
        logic [1:0]  status;
    } ctl_t;

    // Clamp to 16 bits; the top bit of the result flags saturation.
    function automatic logic [16:0] sat16(input logic signed [32:0] v);
        logic [16:0] r;
        if (v > 33'sd32767)
            r = {1'b1, 16'h7fff};
        else if (v < -33'sd32768)
            r = {1'b1, 16'h8000};
        else
            r = {1'b0, v[15:0]};
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/cau_front.sv =====
`default_nettype none

module cau_front #(
    parameter int FRAC_BITS = 8,
    parameter int NW        = 32 + FRAC_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [2:0]          kind,
    input  wire logic signed [15:0]  a_re,
    input  wire logic signed [15:0]  a_im,
    input  wire logic signed [15:0]  b_re,
    input  wire logic signed [15:0]  b_im,
    output cau_pkg::ctl_t            ctl,
    output logic [31:0]              den,
    output logic [NW-1:0]            num_re,
    output logic [NW-1:0]            num_im
);

    localparam int CMPW = 32 + cau_pkg::QW;

    // Stage A: operand capture.
    logic               va_reg;
    logic [2:0]         kind_a_reg;
    logic signed [15:0] ar_a_reg, ai_a_reg, br_a_reg, bi_a_reg;

    // Stage B: products.
    logic               vb_reg;
    logic [2:0]         kind_b_reg;
    logic signed [15:0] ar_b_reg, ai_b_reg, br_b_reg, bi_b_reg;
    logic signed [31:0] rr_reg, ii_reg, ri_reg, ir_reg, bbr_reg, bbi_reg;

    // Stage C outputs.
    cau_pkg::ctl_t      ctl_reg, ctl_next;
    logic [31:0]        den_reg, den_next;
    logic [NW-1:0]      num_re_reg, num_re_next, num_im_reg, num_im_next;

    logic signed [32:0] pm_re, pm_im, nre, nim, tm_re, tm_im, mask, sel_re, sel_im;
    logic [31:0]        mag_re, mag_im;
    logic [16:0]        s_re, s_im;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else
        begin
            va_reg  <= in_valid;
            vb_reg  <= va_reg;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_a_reg <= kind;
        ar_a_reg   <= a_re;
        ai_a_reg   <= a_im;
        br_a_reg   <= b_re;
        bi_a_reg   <= b_im;
        kind_b_reg <= kind_a_reg;
        ar_b_reg   <= ar_a_reg;
        ai_b_reg   <= ai_a_reg;
        br_b_reg   <= br_a_reg;
        bi_b_reg   <= bi_a_reg;
        rr_reg     <= ar_a_reg * br_a_reg;
        ii_reg     <= ai_a_reg * bi_a_reg;
        ri_reg     <= ar_a_reg * bi_a_reg;
        ir_reg     <= ai_a_reg * br_a_reg;
        bbr_reg    <= br_a_reg * br_a_reg;
        bbi_reg    <= bi_a_reg * bi_a_reg;
        den_reg    <= den_next;
        num_re_reg <= num_re_next;
        num_im_reg <= num_im_next;
    end

    always_comb
    begin
        mask  = (33'sd1 <<< FRAC_BITS) - 33'sd1;
        pm_re = 33'(rr_reg) - 33'(ii_reg);
        pm_im = 33'(ri_reg) + 33'(ir_reg);
        // Bias negatives so the shift truncates toward zero.
        tm_re = (pm_re + (pm_re[32] ? mask : 33'sd0)) >>> FRAC_BITS;
        tm_im = (pm_im + (pm_im[32] ? mask : 33'sd0)) >>> FRAC_BITS;

        nre    = 33'(rr_reg) + 33'(ii_reg);
        nim    = 33'(ir_reg) - 33'(ri_reg);
        mag_re = nre[32] ? 32'(-nre) : nre[31:0];
        mag_im = nim[32] ? 32'(-nim) : nim[31:0];

        den_next    = unsigned'(bbr_reg) + unsigned'(bbi_reg);
        num_re_next = NW'(mag_re) << FRAC_BITS;
        num_im_next = NW'(mag_im) << FRAC_BITS;

        case (kind_b_reg)
            cau_pkg::KIND_ADD:
            begin
                sel_re = 33'(ar_b_reg) + 33'(br_b_reg);
                sel_im = 33'(ai_b_reg) + 33'(bi_b_reg);
            end
            cau_pkg::KIND_SUB:
            begin
                sel_re = 33'(ar_b_reg) - 33'(br_b_reg);
                sel_im = 33'(ai_b_reg) - 33'(bi_b_reg);
            end
            cau_pkg::KIND_MUL:
            begin
                sel_re = tm_re;
                sel_im = tm_im;
            end
            cau_pkg::KIND_CONJ:
            begin
                sel_re = 33'(ar_b_reg);
                sel_im = -33'(ai_b_reg);
            end
            default:
            begin
                sel_re = '0;
                sel_im = '0;
            end
        endcase
        s_re = cau_pkg::sat16(sel_re);
        s_im = cau_pkg::sat16(sel_im);

        ctl_next.valid  = vb_reg;
        ctl_next.is_div = (kind_b_reg == cau_pkg::KIND_DIV);
        ctl_next.div0   = (den_next == 32'd0);
        ctl_next.neg_re = nre[32];
        ctl_next.neg_im = nim[32];
        // A quotient of 2^QW or more saturates whatever its low bits are.
        ctl_next.ovf_re = CMPW'(num_re_next) >= (CMPW'(den_next) << cau_pkg::QW);
        ctl_next.ovf_im = CMPW'(num_im_next) >= (CMPW'(den_next) << cau_pkg::QW);
        ctl_next.res_re = s_re[15:0];
        ctl_next.res_im = s_im[15:0];
        ctl_next.status = (s_re[16] || s_im[16]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end

    assign ctl    = ctl_reg;
    assign den    = den_reg;
    assign num_re = num_re_reg;
    assign num_im = num_im_reg;

endmodule

`default_nettype wire

// ===== src/cau_cell.sv =====
`default_nettype none

// One restoring-division step: settles quotient bit BIT for both parts.
module cau_cell #(
    parameter int NW  = 40,
    parameter int BIT = 0
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cau_pkg::ctl_t          ctl_in,
    input  wire logic [31:0]            den_in,
    input  wire logic [NW-1:0]          rem_re_in,
    input  wire logic [NW-1:0]          rem_im_in,
    input  wire logic [cau_pkg::QW-1:0] q_re_in,
    input  wire logic [cau_pkg::QW-1:0] q_im_in,
    output cau_pkg::ctl_t               ctl_out,
    output logic [31:0]                 den_out,
    output logic [NW-1:0]               rem_re_out,
    output logic [NW-1:0]               rem_im_out,
    output logic [cau_pkg::QW-1:0]      q_re_out,
    output logic [cau_pkg::QW-1:0]      q_im_out
);

    localparam int CMPW = 32 + cau_pkg::QW;

    cau_pkg::ctl_t          ctl_reg;
    logic [31:0]            den_reg;
    logic [NW-1:0]          rem_re_reg, rem_re_next, rem_im_reg, rem_im_next;
    logic [cau_pkg::QW-1:0] q_re_reg, q_re_next, q_im_reg, q_im_next;
    logic [CMPW-1:0]        dsh;
    logic                   ge_re, ge_im;

    always_comb
    begin
        dsh         = CMPW'(den_in) << BIT;
        ge_re       = CMPW'(rem_re_in) >= dsh;
        ge_im       = CMPW'(rem_im_in) >= dsh;
        rem_re_next = ge_re ? NW'(CMPW'(rem_re_in) - dsh) : rem_re_in;
        rem_im_next = ge_im ? NW'(CMPW'(rem_im_in) - dsh) : rem_im_in;
        q_re_next      = q_re_in;
        q_re_next[BIT] = ge_re;
        q_im_next      = q_im_in;
        q_im_next[BIT] = ge_im;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        den_reg    <= den_in;
        rem_re_reg <= rem_re_next;
        rem_im_reg <= rem_im_next;
        q_re_reg   <= q_re_next;
        q_im_reg   <= q_im_next;
    end

    assign ctl_out    = ctl_reg;
    assign den_out    = den_reg;
    assign rem_re_out = rem_re_reg;
    assign rem_im_out = rem_im_reg;
    assign q_re_out   = q_re_reg;
    assign q_im_out   = q_im_reg;

endmodule

`default_nettype wire

// ===== src/complex_arithmetic_unit.sv =====
// Channel   Handshake      Ports
// command   start / busy   kind, a_re, a_im, b_re, b_im
// result    done strobe    res_re, res_im, status
//
// One command is taken per cycle; busy is always low.
// Every result passes through three front stages (capture, products, sums),
// one cell per quotient bit (17) and one output stage.
// All operations run the same cell chain, so results leave in order.
// Reset clears the valid bits and control words, not the data path; the receiver cannot stall.
`default_nettype none

`include "complex_arithmetic_unit_assert.svh"

module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         kind,
    input  wire logic signed [15:0] a_re,
    input  wire logic signed [15:0] a_im,
    input  wire logic signed [15:0] b_re,
    input  wire logic signed [15:0] b_im,
    output logic                    done,
    output logic signed [15:0]      res_re,
    output logic signed [15:0]      res_im,
    output logic [1:0]              status
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int QW = cau_pkg::QW;

    cau_pkg::ctl_t   ctl_c [0:QW];
    logic [31:0]     den_c [0:QW];
    logic [NW-1:0]   rre_c [0:QW];
    logic [NW-1:0]   rim_c [0:QW];
    logic [QW-1:0]   qre_c [0:QW];
    logic [QW-1:0]   qim_c [0:QW];

    logic              done_reg;
    logic signed [15:0] res_re_reg, res_re_next, res_im_reg, res_im_next;
    logic [1:0]        status_reg, status_next;
    cau_pkg::ctl_t     last;
    logic              sat_re, sat_im;
    logic [QW-1:0]     q_re, q_im;

    cau_front #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .kind     (kind),
        .a_re     (a_re),
        .a_im     (a_im),
        .b_re     (b_re),
        .b_im     (b_im),
        .ctl      (ctl_c[0]),
        .den      (den_c[0]),
        .num_re   (rre_c[0]),
        .num_im   (rim_c[0])
    );

    assign qre_c[0] = '0;
    assign qim_c[0] = '0;

    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        cau_cell #(.NW(NW), .BIT(QW - 1 - i)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl_in     (ctl_c[i]),
            .den_in     (den_c[i]),
            .rem_re_in  (rre_c[i]),
            .rem_im_in  (rim_c[i]),
            .q_re_in    (qre_c[i]),
            .q_im_in    (qim_c[i]),
            .ctl_out    (ctl_c[i+1]),
            .den_out    (den_c[i+1]),
            .rem_re_out (rre_c[i+1]),
            .rem_im_out (rim_c[i+1]),
            .q_re_out   (qre_c[i+1]),
            .q_im_out   (qim_c[i+1])
        );
    end

    always_comb
    begin
        last = ctl_c[QW];
        q_re = qre_c[QW];
        q_im = qim_c[QW];
        // A negative quotient may reach 32768 before it clamps.
        sat_re = last.ovf_re || (last.neg_re ? (q_re > QW'(32768)) : (q_re > QW'(32767)));
        sat_im = last.ovf_im || (last.neg_im ? (q_im > QW'(32768)) : (q_im > QW'(32767)));
        if (!last.is_div)
        begin
            res_re_next = last.res_re;
            res_im_next = last.res_im;
            status_next = last.status;
        end
        else if (last.div0)
        begin
            res_re_next = '0;
            res_im_next = '0;
            status_next = cau_pkg::ST_DIV0;
        end
        else
        begin
            if (sat_re)
                res_re_next = last.neg_re ? 16'sh8000 : 16'sh7fff;
            else
                res_re_next = last.neg_re ? 16'(-q_re) : q_re[15:0];
            if (sat_im)
                res_im_next = last.neg_im ? 16'sh8000 : 16'sh7fff;
            else
                res_im_next = last.neg_im ? 16'(-q_im) : q_im[15:0];
            status_next = (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= last.valid;
    end

    always_ff @(posedge clk)
    begin
        res_re_reg <= res_re_next;
        res_im_reg <= res_im_next;
        status_reg <= status_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign res_re = res_re_reg;
    assign res_im = res_im_reg;
    assign status = status_reg;

    `CAU_ASSERT_NOW(a_status_code, done, status != 2'd3)
    `CAU_ASSERT_NOW(a_div0_zero, done && status == cau_pkg::ST_DIV0, res_re == 16'sd0 && res_im == 16'sd0)
    `CAU_ASSERT_NOW(a_sat_bound, done && status == cau_pkg::ST_SAT, res_re == 16'sh7fff || res_re == 16'sh8000 || res_im == 16'sh7fff || res_im == 16'sh8000)
    `CAU_ASSERT_NEXT(a_chain_done, last.valid, done)

endmodule

`default_nettype wire

// ===== dv/tb_complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    localparam int FRAC = 8;
    localparam int LATENCY = 21;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 750;

    typedef struct packed {
        logic [15:0] re;
        logic [15:0] im;
        logic [1:0]  st;
    } cplx_res_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] ar;
        logic [15:0] ai;
        logic [15:0] br;
        logic [15:0] bi;
        logic        typed;
        cplx_res_t   res;
    } cmd_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [2:0] kind;
    logic signed [15:0] a_re, a_im, b_re, b_im;
    logic done;
    logic signed [15:0] res_re, res_im;
    logic [1:0] status;

    cplx_res_t pending_results[$];
    int errors;
    int idle_cycles;
    bit stim_done;

    complex_arithmetic_unit #(.FRAC_BITS(FRAC)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
        .done(done), .res_re(res_re), .res_im(res_im), .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [15:0] clamp_part(input longint v, inout bit sat);
        if (v > 32767)
        begin
            sat = 1'b1;
            return 16'h7fff;
        end
        if (v < -32768)
        begin
            sat = 1'b1;
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    // Wide products are exact; SystemVerilog division truncates toward zero.
    function automatic cplx_res_t complex_result(input logic [2:0] op,
            input logic signed [15:0] ar, input logic signed [15:0] ai,
            input logic signed [15:0] br, input logic signed [15:0] bi);
        longint xr, xi, yr, yi, re, im, den, scale;
        bit sat;
        cplx_res_t r;
        xr = ar; xi = ai; yr = br; yi = bi;
        re = 0; im = 0; sat = 1'b0;
        scale = longint'(1) << FRAC;
        r.st = ST_OK;
        case (op)
            KIND_ADD:
            begin
                re = xr + yr; im = xi + yi;
            end
            KIND_SUB:
            begin
                re = xr - yr; im = xi - yi;
            end
            KIND_MUL:
            begin
                re = (xr * yr - xi * yi) / scale;
                im = (xr * yi + xi * yr) / scale;
            end
            KIND_DIV:
            begin
                den = yr * yr + yi * yi;
                if (den == 0)
                    r.st = ST_DIV0;
                else
                begin
                    re = ((xr * yr + xi * yi) * scale) / den;
                    im = ((xi * yr - xr * yi) * scale) / den;
                end
            end
            KIND_CONJ:
            begin
                re = xr; im = -xi;
            end
            default: ;
        endcase
        r.re = clamp_part(re, sat);
        r.im = clamp_part(im, sat);
        if (sat)
            r.st = ST_SAT;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
            input logic [15:0] want);
        errors++;
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t result transfer with nothing expected", $realtime);
                end
                else
                begin
                    cplx_res_t e;
                    e = pending_results.pop_front();
                    if (res_re !== e.re) report_mismatch("res_re", res_re, e.re);
                    if (res_im !== e.im) report_mismatch("res_im", res_im, e.im);
                    if (status !== e.st) report_mismatch("status", {14'd0, status}, {14'd0, e.st});
                end
            end
        end
    end

    // Holds a command until it is taken; the caller decides whether start stays up.
    task automatic send_cmd(input logic [2:0] op, input logic [15:0] ar,
            input logic [15:0] ai, input logic [15:0] br, input logic [15:0] bi,
            input bit typed, input cplx_res_t want);
        cplx_res_t p;
        start <= 1'b1;
        kind <= op; a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
        do
            @(posedge clk);
        while (busy);
        p = complex_result(op, ar, ai, br, bi);
        if (typed && p !== want)
        begin
            errors++;
            $display("%0t directed row disagrees with prediction", $realtime);
        end
        pending_results.push_back(typed ? want : p);
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_operand(input bit narrow);
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: ;
        endcase
        if (narrow)
            return 16'($signed($urandom_range(0, 1023)) - 512);
        return 16'($urandom);
    endfunction

    cmd_row_t directed[] = '{
        '{KIND_ADD,  16'h0100, 16'h0200, 16'h0300, 16'h0400, 1, '{16'h0400, 16'h0600, ST_OK}},
        '{KIND_ADD,  16'h7fff, 16'h8000, 16'h0001, 16'hffff, 1, '{16'h7fff, 16'h8000, ST_SAT}},
        '{KIND_ADD,  16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1, '{16'hffff, 16'hffff, ST_OK}},
        '{KIND_SUB,  16'h8000, 16'h7fff, 16'h0001, 16'hffff, 1, '{16'h8000, 16'h7fff, ST_SAT}},
        '{KIND_SUB,  16'h0500, 16'h0000, 16'h0200, 16'h0100, 1, '{16'h0300, 16'hff00, ST_OK}},
        '{KIND_MUL,  16'h0100, 16'h0000, 16'h1234, 16'hedcc, 1, '{16'h1234, 16'hedcc, ST_OK}},
        '{KIND_MUL,  16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1, '{16'h0000, 16'h7fff, ST_SAT}},
        '{KIND_MUL,  16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, '0},
        '{KIND_MUL,  16'hffff, 16'h0000, 16'h0001, 16'h0000, 0, '0},
        '{KIND_DIV,  16'h1234, 16'h5678, 16'h0000, 16'h0000, 1, '{16'h0000, 16'h0000, ST_DIV0}},
        '{KIND_DIV,  16'h0300, 16'h0000, 16'h0100, 16'h0000, 1, '{16'h0300, 16'h0000, ST_OK}},
        '{KIND_DIV,  16'h7fff, 16'h7fff, 16'h0001, 16'h0000, 1, '{16'h7fff, 16'h7fff, ST_SAT}},
        '{KIND_DIV,  16'h8000, 16'h7fff, 16'h8000, 16'h8000, 0, '0},
        '{KIND_DIV,  16'hffff, 16'h0001, 16'h0003, 16'hfffd, 0, '0},
        '{KIND_CONJ, 16'h1234, 16'h0100, 16'h5555, 16'haaaa, 1, '{16'h1234, 16'hff00, ST_OK}},
        '{KIND_CONJ, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 1, '{16'h8000, 16'h7fff, ST_SAT}},
        '{KIND_CONJ, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 1, '{16'h7fff, 16'h8001, ST_OK}},
        '{3'd5,      16'h1111, 16'h2222, 16'h3333, 16'h4444, 1, '{16'h0000, 16'h0000, ST_OK}},
        '{3'd6,      16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, '{16'h0000, 16'h0000, ST_OK}},
        '{3'd7,      16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1, '{16'h0000, 16'h0000, ST_OK}}
    };

    initial
    begin
        int burst;
        int gap;
        cplx_res_t none;
        none = '0;
        errors = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        kind = KIND_ADD;
        a_re = '0; a_im = '0; b_re = '0; b_im = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_cmd(directed[i].op, directed[i].ar, directed[i].ai, directed[i].br,
                     directed[i].bi, directed[i].typed, directed[i].res);

        burst = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            bit narrow;
            logic [2:0] op;
            if (burst == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                // Start only drops when a gap follows, so it is driven once per edge.
                if (gap > 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                burst = $urandom_range(1, 30);
            end
            burst--;
            narrow = $urandom_range(0, 1);
            op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            send_cmd(op, rand_operand(narrow), rand_operand(narrow),
                     rand_operand(narrow), rand_operand(narrow), 1'b0, none);
        end
        start <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        while (pending_results.size() != 0 && idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        if (pending_results.size() == 0)
            repeat (LATENCY + 5) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb_complex_arithmetic_unit: PASS");
        else
            $display("tb_complex_arithmetic_unit: FAIL");
        $finish;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT && !stim_done);
        $display("tb_complex_arithmetic_unit: FAIL");
        $finish;
    end

endmodule
